[rtl/ptu_pkg.sv]
// ----------------------------------------------------------------------------
// ptu_pkg
// Shared types and constants of the two-level page table updater: sequencer
// states, arithmetic unit operations, field widths and the result record.
// ----------------------------------------------------------------------------
package ptu_pkg;

  localparam int VP_W    = 20;
  localparam int FRAME_W = 20;
  localparam int PRIV_W  = 2;
  localparam int IDX_W   = 10;
  localparam int LEFT_W  = 11;
  localparam int ALU_W   = 11;
  localparam int DIR_W   = 2;

  // directory entry bits
  localparam int DIR_PRES_BIT  = 0;
  localparam int DIR_ALLOC_BIT = 1;

  // table entry bits
  localparam int E_PRESENT_BIT = 0;
  localparam int E_USER_BIT    = 1;
  localparam int E_RW_BIT      = 2;
  localparam int E_FRAME_SHIFT = 3;

  localparam logic ACT_MAP   = 1'b0;
  localparam logic ACT_UNMAP = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_DIR,
    S_DECIDE,
    S_RMW,
    S_WIPE,
    S_WRITE,
    S_COUNT,
    S_LAST,
    S_FINAL
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic              status;
    logic              table_created;
    logic              table_released;
    logic [LEFT_W-1:0] entries_left;
  } result_t;

endpackage

[rtl/ptu_ram.sv]
// ----------------------------------------------------------------------------
// ptu_ram
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module ptu_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/ptu_alu.sv]
// ----------------------------------------------------------------------------
// ptu_alu
// Shared add / compare-subtract unit used for index reduction and for the
// present-entry count.
// ----------------------------------------------------------------------------
module ptu_alu (
  input  ptu_pkg::alu_op_e            op,
  input  logic [ptu_pkg::ALU_W-1:0]   a,
  input  logic [ptu_pkg::ALU_W-1:0]   b,
  output logic [ptu_pkg::ALU_W-1:0]   y,
  output logic                        ge
);
  import ptu_pkg::*;

  logic [ALU_W:0] diff;

  always_comb begin
    diff = {1'b0, a} - {1'b0, b};
    ge   = ~diff[ALU_W];
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = diff[ALU_W-1:0];
      default: y = a + b;
    endcase
  end

endmodule

[rtl/ptu_seq.sv]
// ----------------------------------------------------------------------------
// ptu_seq
// Sequencer of the page table updater: directory clearing pass, index
// reduction, table wipe, entry update and present-entry walk.
// ----------------------------------------------------------------------------
module ptu_seq #(
  parameter int DIR_ENTRIES   = 1024,
  parameter int TABLE_ENTRIES = 1024,
  parameter int FRAME_BITS    = 20,
  localparam int DW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1,
  localparam int TW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int TAW = $clog2(DIR_ENTRIES * TABLE_ENTRIES),
  localparam int EW  = FRAME_BITS + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [ptu_pkg::VP_W-1:0]      virt_page,
  input  logic [ptu_pkg::FRAME_W-1:0]   phys_frame,
  input  logic [ptu_pkg::PRIV_W-1:0]    privilege,
  input  logic                          res_ready,
  output logic                          res_load,
  output ptu_pkg::result_t              res,
  output logic                          dir_wr_en,
  output logic [DW-1:0]                 dir_wr_addr,
  output logic [ptu_pkg::DIR_W-1:0]     dir_wr_data,
  output logic                          dir_rd_en,
  output logic [DW-1:0]                 dir_rd_addr,
  input  logic [ptu_pkg::DIR_W-1:0]     dir_rd_data,
  output logic                          tbl_wr_en,
  output logic [TAW-1:0]                tbl_wr_addr,
  output logic [EW-1:0]                 tbl_wr_data,
  output logic                          tbl_rd_en,
  output logic [TAW-1:0]                tbl_rd_addr,
  input  logic [EW-1:0]                 tbl_rd_data
);
  import ptu_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  state_e            state, state_next;
  logic [DW-1:0]     clr_idx;
  logic              mod_dir;
  logic              action_r;
  logic              invalid_r;
  logic [IDX_W-1:0]  ti_r;
  logic [IDX_W-1:0]  di_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic              user_r;
  logic [TAW-1:0]    tbase;
  logic [TW-1:0]     idx;
  logic              pend;
  logic [CW-1:0]     cnt;
  logic              status_r;
  logic              created_r;
  logic              walked_r;

  alu_op_e           alu_op;
  logic [ALU_W-1:0]  alu_a, alu_b, alu_y;
  logic              alu_ge;

  logic              need_new;
  logic              dir_alloc;
  logic              idx_last;
  logic              released;
  logic [TAW-1:0]    addr_ti, addr_idx;
  logic [EW-1:0]     map_entry;

  ptu_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .ge (alu_ge)
  );

  assign dir_alloc = dir_rd_data[DIR_ALLOC_BIT];
  assign need_new  = ~(dir_rd_data[DIR_ALLOC_BIT] & dir_rd_data[DIR_PRES_BIT]);
  assign idx_last  = (idx == TW'(TABLE_ENTRIES - 1));
  assign addr_ti   = TAW'(tbase + TAW'(ti_r[TW-1:0]));
  assign addr_idx  = TAW'(tbase + TAW'(idx));
  assign map_entry = {frame_r, 1'b1, user_r, 1'b1};
  assign released  = (action_r == ACT_UNMAP) && walked_r && (cnt == '0);

  // shared unit operands
  always_comb begin
    if (state == S_MOD) begin
      alu_op = ALU_SUB;
      alu_a  = mod_dir ? ALU_W'(di_r) : ALU_W'(ti_r);
      alu_b  = mod_dir ? ALU_W'(DIR_ENTRIES) : ALU_W'(TABLE_ENTRIES);
    end else begin
      alu_op = ALU_ADD;
      alu_a  = ALU_W'(cnt);
      alu_b  = ALU_W'(tbl_rd_data[E_PRESENT_BIT]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == DW'(DIR_ENTRIES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_MOD;
      end
      S_MOD: begin
        if (!alu_ge && mod_dir) state_next = S_DIR;
      end
      S_DIR: state_next = S_DECIDE;
      S_DECIDE: begin
        if (invalid_r) begin
          state_next = S_FINAL;
        end else if (action_r == ACT_MAP) begin
          state_next = need_new ? S_WIPE : S_WRITE;
        end else begin
          state_next = dir_alloc ? S_RMW : S_FINAL;
        end
      end
      S_RMW: state_next = S_COUNT;
      S_WIPE: begin
        if (idx_last) state_next = S_WRITE;
      end
      S_WRITE: state_next = created_r ? S_FINAL : S_COUNT;
      S_COUNT: begin
        if (idx_last) state_next = S_LAST;
      end
      S_LAST: state_next = S_FINAL;
      S_FINAL: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    res_load    = 1'b0;
    dir_wr_en   = 1'b0;
    dir_wr_addr = di_r[DW-1:0];
    dir_wr_data = '0;
    dir_rd_en   = 1'b0;
    dir_rd_addr = di_r[DW-1:0];
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = addr_ti;
    tbl_wr_data = map_entry;
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = addr_idx;
    unique case (state)
      S_CLEAR: begin
        dir_wr_en   = 1'b1;
        dir_wr_addr = clr_idx;
      end
      S_IDLE: in_ready = 1'b1;
      S_MOD: ;
      S_DIR: dir_rd_en = 1'b1;
      S_DECIDE: begin
        if (!invalid_r && action_r == ACT_MAP && need_new) begin
          dir_wr_en = 1'b1;
          dir_wr_data[DIR_ALLOC_BIT] = 1'b1;
          dir_wr_data[DIR_PRES_BIT]  = 1'b1;
        end
        if (!invalid_r && action_r == ACT_UNMAP && dir_alloc) begin
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = addr_ti;
        end
      end
      S_RMW: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_data = tbl_rd_data & ~EW'(1);
      end
      S_WIPE: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = addr_idx;
        tbl_wr_data = '0;
      end
      S_WRITE: tbl_wr_en = 1'b1;
      S_COUNT: tbl_rd_en = 1'b1;
      S_LAST: ;
      S_FINAL: begin
        res_load = res_ready;
        if (released) begin
          dir_wr_en = 1'b1;
          dir_wr_data[DIR_ALLOC_BIT] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res.status         = status_r;
  assign res.table_created  = created_r;
  assign res.table_released = released;
  assign res.entries_left   = LEFT_W'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      mod_dir  <= 1'b0;
      pend     <= 1'b0;
      walked_r <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_idx <= clr_idx + DW'(1);
        S_IDLE: begin
          if (in_valid) begin
            action_r  <= action;
            invalid_r <= (virt_page == '0) || (action == ACT_MAP && phys_frame == '0);
            ti_r      <= virt_page[IDX_W-1:0];
            di_r      <= virt_page[VP_W-1:IDX_W];
            frame_r   <= FRAME_BITS'(phys_frame);
            user_r    <= (privilege != '0);
            mod_dir   <= 1'b0;
          end
        end
        S_MOD: begin
          if (alu_ge) begin
            if (mod_dir) di_r <= alu_y[IDX_W-1:0];
            else         ti_r <= alu_y[IDX_W-1:0];
          end else begin
            mod_dir <= 1'b1;
          end
        end
        S_DIR: tbase <= TAW'(di_r[DW-1:0] * TABLE_ENTRIES);
        S_DECIDE: begin
          cnt       <= '0;
          idx       <= '0;
          walked_r  <= 1'b0;
          status_r  <= invalid_r;
          created_r <= !invalid_r && (action_r == ACT_MAP) && need_new;
        end
        S_RMW: begin
          walked_r <= 1'b1;
          idx      <= '0;
          pend     <= 1'b0;
        end
        S_WIPE: idx <= idx_last ? '0 : idx + TW'(1);
        S_WRITE: begin
          // a fresh table holds only the new entry
          if (created_r) begin
            cnt <= CW'(1);
          end else begin
            walked_r <= 1'b1;
          end
          idx  <= '0;
          pend <= 1'b0;
        end
        S_COUNT: begin
          pend <= 1'b1;
          if (pend) cnt <= alu_y[CW-1:0];
          idx <= idx_last ? '0 : idx + TW'(1);
        end
        S_LAST: begin
          cnt  <= alu_y[CW-1:0];
          pend <= 1'b0;
        end
        S_FINAL: ;
        default: ;
      endcase
    end
  end

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> state == S_CLEAR)
    else $error("sequencer not in clearing pass after reset");

  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res_ready)
    else $error("result loaded while output register full");

  a_release_empty: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.table_released) |->
      (!res.status && !res.table_created && res.entries_left == '0))
    else $error("table released with entries left or bad status");

  a_create_one: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.table_created) |-> (!res.status && res.entries_left == LEFT_W'(1)))
    else $error("fresh table does not hold exactly one entry");

  a_walk_reads: assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT) |=> (pend && (state == S_COUNT || state == S_LAST)))
    else $error("present walk lost its read pipeline");

endmodule

[rtl/two_level_page_table_updater_top.sv]
// ----------------------------------------------------------------------------
// two_level_page_table_updater_top
// Two-level page directory and table updater with map and unmap requests.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one map or unmap request: tuser is the action (0 map,
//   1 unmap), tdata holds virtual page, frame and privilege. m_axis returns
//   one result per request: tuser is the status, tdata the table flags and
//   the present count left in the touched table.
// work per request
//   invalid request or unmap with no table: directory read only
//   map into an existing table, or unmap: entry update, then a walk of the table
//   map that creates a table: table wipe, then the entry write (no walk)
//   with fewer entries than the index range, the indices are reduced by
//   repeated subtraction first
//   the one table port wipes or counts one entry a cycle
//   one request at a time: the next is taken the cycle after a result loads
// reset
//   a clearing pass over all DIR_ENTRIES entries empties the directory; no request
//   is taken until it ends
// stall
//   a result waits in the output register; the next request is taken and
//   worked on, and its result holds in the sequencer until the register frees
// ----------------------------------------------------------------------------
module two_level_page_table_updater_top #(
  parameter int DIR_ENTRIES   = 1024,
  parameter int TABLE_ENTRIES = 1024,
  parameter int FRAME_BITS    = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // virt_page, phys_frame, privilege
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // table_created, table_released, entries_left
  output logic        m_axis_tuser    // status
);
  import ptu_pkg::*;

  localparam int DW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int TAW = $clog2(DIR_ENTRIES * TABLE_ENTRIES);
  localparam int EW  = FRAME_BITS + 3;

  logic            res_ready, res_load;
  result_t         res, out_res;
  logic            out_valid;

  logic            dir_wr_en, dir_rd_en;
  logic [DW-1:0]   dir_wr_addr, dir_rd_addr;
  logic [DIR_W-1:0] dir_wr_data, dir_rd_data;
  logic            tbl_wr_en, tbl_rd_en;
  logic [TAW-1:0]  tbl_wr_addr, tbl_rd_addr;
  logic [EW-1:0]   tbl_wr_data, tbl_rd_data;

  ptu_seq #(
    .DIR_ENTRIES   (DIR_ENTRIES),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRAME_BITS    (FRAME_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .action      (s_axis_tuser),
    .virt_page   (s_axis_tdata[19:0]),
    .phys_frame  (s_axis_tdata[39:20]),
    .privilege   (s_axis_tdata[41:40]),
    .res_ready   (res_ready),
    .res_load    (res_load),
    .res         (res),
    .dir_wr_en   (dir_wr_en),
    .dir_wr_addr (dir_wr_addr),
    .dir_wr_data (dir_wr_data),
    .dir_rd_en   (dir_rd_en),
    .dir_rd_addr (dir_rd_addr),
    .dir_rd_data (dir_rd_data),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data),
    .tbl_rd_en   (tbl_rd_en),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd_data (tbl_rd_data)
  );

  ptu_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_ENTRIES)
  ) u_dir_ram (
    .clk     (clk),
    .wr_en   (dir_wr_en),
    .wr_addr (dir_wr_addr),
    .wr_data (dir_wr_data),
    .rd_en   (dir_rd_en),
    .rd_addr (dir_rd_addr),
    .rd_data (dir_rd_data)
  );

  ptu_ram #(
    .WIDTH (EW),
    .DEPTH (DIR_ENTRIES * TABLE_ENTRIES)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  // output register
  assign res_ready = ~out_valid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {3'b000, out_res.entries_left, out_res.table_released,
                          out_res.table_created};

endmodule

[dv/two_level_page_table_updater_checker.sv]
// ----------------------------------------------------------------------------
// two_level_page_table_updater_checker
// Watches both stream channels of the page table updater. Every accepted
// request is run through a shadow directory and present-bit table to get the
// expected status, table flags and remaining count. Each returned result is
// compared with the oldest outstanding expectation, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module two_level_page_table_updater_checker #(
  parameter int DIR_ENTRIES   = 1024,
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned map_count,
  output int unsigned unmap_count,
  output int unsigned created_count,
  output int unsigned released_count
);
  import ptu_pkg::*;

  localparam logic ST_INVALID = 1'b1;

  bit          dir_present [DIR_ENTRIES];
  bit          dir_alloc   [DIR_ENTRIES];
  bit          pte_present [DIR_ENTRIES*TABLE_ENTRIES];
  int unsigned pte_count   [DIR_ENTRIES];

  result_t     expected_q [$];
  int unsigned errors;
  int unsigned n_map;
  int unsigned n_unmap;
  int unsigned n_created;
  int unsigned n_released;
  int unsigned n_results;

  function automatic result_t apply_update(logic action, logic [VP_W-1:0] vp,
                                           logic [FRAME_W-1:0] frame);
    int unsigned di;
    int unsigned ti;
    int unsigned slot;
    int unsigned i;
    result_t     res;
    res  = '0;
    ti   = vp[IDX_W-1:0] % TABLE_ENTRIES;
    di   = vp[2*IDX_W-1:IDX_W] % DIR_ENTRIES;
    slot = di * TABLE_ENTRIES + ti;
    if (action == ACT_MAP) begin
      if (vp == '0 || frame == '0) begin
        res.status = ST_INVALID;
      end else begin
        if (!dir_alloc[di] || !dir_present[di]) begin
          for (i = 0; i < TABLE_ENTRIES; i++) pte_present[di*TABLE_ENTRIES+i] = 1'b0;
          pte_count[di]      = 0;
          dir_alloc[di]      = 1'b1;
          dir_present[di]    = 1'b1;
          res.table_created  = 1'b1;
        end
        if (!pte_present[slot]) pte_count[di]++;
        pte_present[slot] = 1'b1;
        res.entries_left  = LEFT_W'(pte_count[di]);
      end
    end else begin
      if (vp == '0) begin
        res.status = ST_INVALID;
      end else if (dir_alloc[di]) begin
        if (pte_present[slot]) pte_count[di]--;
        pte_present[slot] = 1'b0;
        res.entries_left  = LEFT_W'(pte_count[di]);
        if (pte_count[di] == 0) begin
          dir_present[di]    = 1'b0;
          res.table_released = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    result_t     want;
    result_t     got;
    int unsigned i;
    if (rst) begin
      for (i = 0; i < DIR_ENTRIES; i++) begin
        dir_present[i] = 1'b0;
        dir_alloc[i]   = 1'b0;
      end
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_update(s_axis_tuser, s_axis_tdata[VP_W-1:0],
                            s_axis_tdata[VP_W+FRAME_W-1:VP_W]);
        expected_q.push_back(want);
        if (s_axis_tuser == ACT_MAP) n_map++;
        else n_unmap++;
        if (want.table_created) n_created++;
        if (want.table_released) n_released++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        got.status         = m_axis_tuser;
        got.table_created  = m_axis_tdata[0];
        got.table_released = m_axis_tdata[1];
        got.entries_left   = m_axis_tdata[LEFT_W+1:2];
        if (expected_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: #%0d no request outstanding, got %0d/%0d/%0d/%0d",
                     $realtime, n_results, got.status, got.table_created,
                     got.table_released, got.entries_left);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.table_created !== want.table_created ||
              got.table_released !== want.table_released ||
              got.entries_left !== want.entries_left) begin
            if (errors < 10)
              $display(
                "%0t: #%0d status/created/released/left exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                $realtime, n_results, want.status, want.table_created,
                want.table_released, want.entries_left, got.status,
                got.table_created, got.table_released, got.entries_left);
            errors++;
          end
        end
      end
    end
    fail_count     <= errors;
    pending        <= expected_q.size();
    map_count      <= n_map;
    unmap_count    <= n_unmap;
    created_count  <= n_created;
    released_count <= n_released;
  end

endmodule

[dv/two_level_page_table_updater_top_test.sv]
// ----------------------------------------------------------------------------
// two_level_page_table_updater_top_test
// Drives map and unmap requests into the page table updater: a directed set
// covering invalid arguments, table creation, remap, release and re-creation,
// then random requests aimed at a few directory slots so tables fill and
// empty again. Both sides idle at random; the result side is held off once
// long enough to back up the input, and the request side drains once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module two_level_page_table_updater_top_test;
  import ptu_pkg::*;

  localparam int RANDOM_ITEMS = 561;
  localparam int LONG_HOLD    = 5000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned map_count;
  int unsigned unmap_count;
  int unsigned created_count;
  int unsigned released_count;

  bit              hold_due  = 1'b0;
  bit              hold_done = 1'b0;
  bit              no_idle   = 1'b0;
  logic [VP_W-1:0] mapped_q [$];

  always #5 clk = ~clk;

  two_level_page_table_updater_top u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  two_level_page_table_updater_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .map_count     (map_count),
    .unmap_count   (unmap_count),
    .created_count (created_count),
    .released_count(released_count)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // valid stays high across back-to-back requests
  task automatic send_request(input logic act, input logic [VP_W-1:0] vp,
                              input logic [FRAME_W-1:0] frame,
                              input logic [PRIV_W-1:0] priv);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'b0, priv, frame, vp};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned        k;
    int unsigned        r;
    int unsigned        pick;
    logic               act;
    logic [IDX_W-1:0]   di;
    logic [IDX_W-1:0]   ti;
    logic [VP_W-1:0]    vp;
    logic [FRAME_W-1:0] frame;
    logic [PRIV_W-1:0]  priv;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(ACT_UNMAP, 20'h00401, 20'h12345, 2'd0);
    send_request(ACT_MAP,   20'h00000, 20'h12345, 2'd1);
    send_request(ACT_MAP,   20'h00005, 20'h00000, 2'd2);
    send_request(ACT_UNMAP, 20'h00000, 20'h00000, 2'd0);
    send_request(ACT_MAP,   20'hFFFFF, 20'hFFFFF, 2'd3);
    send_request(ACT_MAP,   20'hFFFFE, 20'h00001, 2'd0);
    send_request(ACT_MAP,   20'hFFFFF, 20'hAAAAA, 2'd1);
    send_request(ACT_UNMAP, 20'hFFFFF, 20'h00000, 2'd0);
    send_request(ACT_UNMAP, 20'hFFFFE, 20'h00000, 2'd0);
    // directory entry already dropped, table still allocated
    send_request(ACT_UNMAP, 20'hFFFFE, 20'h00000, 2'd3);
    send_request(ACT_MAP,   20'hFFC00, 20'h55555, 2'd2);
    send_request(ACT_MAP,   20'h00001, 20'h80000, 2'd1);
    send_request(ACT_MAP,   20'h003FF, 20'h7FFFF, 2'd0);
    send_request(ACT_MAP,   20'h55555, 20'h2AAAA, 2'd3);
    send_request(ACT_MAP,   20'hAAAAA, 20'h55555, 2'd2);
    send_request(ACT_UNMAP, 20'h003FE, 20'h00000, 2'd0);
    send_request(ACT_UNMAP, 20'h00001, 20'h00000, 2'd0);
    send_request(ACT_UNMAP, 20'h003FF, 20'h00000, 2'd0);
    send_request(ACT_UNMAP, 20'hFFC00, 20'h00000, 2'd0);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (k == 100) hold_due = 1'b1;
      if (k == 300) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end

      // a few directory slots and table slots so tables fill and empty
      case ($urandom_range(0, 4))
        0:       di = 10'h000;
        1:       di = 10'h001;
        2:       di = 10'h155;
        3:       di = 10'h2AA;
        default: di = 10'h3FF;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        ti = IDX_W'($urandom_range(0, 1023));
      end else begin
        case ($urandom_range(0, 5))
          0:       ti = 10'h000;
          1:       ti = 10'h001;
          2:       ti = 10'h155;
          3:       ti = 10'h2AA;
          4:       ti = 10'h3FE;
          default: ti = 10'h3FF;
        endcase
      end
      vp    = {di, ti};
      priv  = PRIV_W'($urandom_range(0, 3));
      frame = ($urandom_range(0, 49) == 0) ? '0 : FRAME_W'($urandom_range(1, 20'hFFFFF));
      act   = ACT_MAP;
      r     = $urandom_range(0, 99);
      if (r < 45) begin
        mapped_q.push_back(vp);
      end else if (r < 85) begin
        act = ACT_UNMAP;
        if (mapped_q.size() > 0) begin
          pick = $urandom_range(0, mapped_q.size() - 1);
          vp   = mapped_q[pick];
          mapped_q.delete(pick);
        end
      end else if (r < 90) begin
        act = ACT_UNMAP;
      end else if (r < 96) begin
        act = 1'($urandom_range(0, 1));
        vp  = VP_W'($urandom_range(0, 20'hFFFFF));
      end else begin
        act = 1'($urandom_range(0, 1));
        vp  = '0;
      end
      send_request(act, vp, frame, priv);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1100) @(posedge clk);

    $display("run covered %0d map and %0d unmap requests", map_count, unmap_count);
    $display("tables created %0d times and released %0d times", created_count,
             released_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    int unsigned hold_cycles;
    forever begin
      if (hold_due && !hold_done) begin
        m_axis_tready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin : watchdog
    #30ms;
    $display("timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
